>>> design/qlhw_pkg.sv
// Package for the QUIC long-header walker.
// Holds the parse phase type, result kind codes, the event record passed
// from the walker to the result serializer, and default sizing constants.
`default_nettype none

package qlhw_pkg;

	localparam int unsigned MAX_ID_BYTES_DEF      = 20;
	localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 65535;
	localparam int unsigned EVQ_DEPTH             = 4;

	typedef enum logic [3:0] {
		PH_FIRST     = 4'd0,
		PH_VERSION   = 4'd1,
		PH_DLEN      = 4'd2,
		PH_DBODY     = 4'd3,
		PH_SLEN      = 4'd4,
		PH_SBODY     = 4'd5,
		PH_TOKV      = 4'd6,
		PH_TOKV_MORE = 4'd7,
		PH_TOKBODY   = 4'd8,
		PH_LENV      = 4'd9,
		PH_LENV_MORE = 4'd10,
		PH_BODY      = 4'd11,
		PH_RETRY     = 4'd12,
		PH_DONE      = 4'd13
	} phase_t;

	localparam logic [2:0] KIND_PACKET    = 3'd0;
	localparam logic [2:0] KIND_ALL_LONG  = 3'd1;
	localparam logic [2:0] KIND_SHORT     = 3'd2;
	localparam logic [2:0] KIND_UNCERTAIN = 3'd3;
	localparam logic [2:0] KIND_UNTOUCHED = 3'd4;

	localparam logic [1:0] TYPE_INITIAL = 2'd0;
	localparam logic [1:0] TYPE_RETRY   = 2'd3;

	typedef struct packed {
		logic        pkt_v;
		logic [1:0]  pkt_type;
		logic [31:0] version;
		logic [4:0]  dest_len;
		logic [4:0]  source_len;
		logic [15:0] pkt_offset;
		logic [15:0] pkt_size;
		logic        term_v;
		logic [2:0]  term_kind;
		logic [15:0] term_offset;
	} event_t;

endpackage

`default_nettype wire

>>> design/qlhw_front.sv
// Front part of the QUIC long-header walker: takes one payload byte per cycle
// while take is high, walks the long headers and produces one event record per
// byte that ends something. Depends on qlhw_pkg.
`default_nettype none

module qlhw_front import qlhw_pkg::*; #(
	parameter int unsigned MAX_ID_BYTES      = MAX_ID_BYTES_DEF,
	parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output event_t          ev,
	output logic            ev_wr
);

	localparam logic [7:0]  MaxId  = 8'(MAX_ID_BYTES);
	localparam logic [15:0] MaxPay = 16'(MAX_PAYLOAD_BYTES);

	phase_t      phase_q, n_phase;
	logic [15:0] pos_q, n_pos;
	logic [15:0] begin_q, n_begin;
	logic [15:0] left_q, n_left;
	logic [15:0] acc_q, n_acc;
	logic        big_q, n_big;
	logic [31:0] ver_q, n_ver;
	logic [1:0]  type_q, n_type;
	logic [4:0]  dl_q, n_dl;
	logic [4:0]  sl_q, n_sl;
	logic        saw_q, n_saw;
	logic [2:0]  outc_q, n_outc;
	logic [15:0] short_q, n_short;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			pos_q   <= '0;
			begin_q <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			big_q   <= 1'b0;
			ver_q   <= '0;
			type_q  <= '0;
			dl_q    <= '0;
			sl_q    <= '0;
			saw_q   <= 1'b0;
			outc_q  <= KIND_ALL_LONG;
			short_q <= '0;
		end else if (take) begin
			phase_q <= n_phase;
			pos_q   <= n_pos;
			begin_q <= n_begin;
			left_q  <= n_left;
			acc_q   <= n_acc;
			big_q   <= n_big;
			ver_q   <= n_ver;
			type_q  <= n_type;
			dl_q    <= n_dl;
			sl_q    <= n_sl;
			saw_q   <= n_saw;
			outc_q  <= n_outc;
			short_q <= n_short;
		end
	end

	always_comb begin
		logic        vzero;
		logic        vover;
		logic [15:0] size;
		n_phase = phase_q;
		n_pos   = pos_q;
		n_begin = begin_q;
		n_left  = left_q;
		n_acc   = acc_q;
		n_big   = big_q;
		n_ver   = ver_q;
		n_type  = type_q;
		n_dl    = dl_q;
		n_sl    = sl_q;
		n_saw   = saw_q;
		n_outc  = outc_q;
		n_short = short_q;
		ev      = '0;
		size    = 16'(pos_q - begin_q + 16'd1);
		vzero   = 1'b0;
		vover   = 1'b0;

		if (phase_q != PH_DONE && pos_q >= MaxPay) begin
			n_phase = PH_DONE;
			n_outc  = KIND_UNCERTAIN;
		end else begin
			case (phase_q)
				PH_FIRST: begin
					n_begin = pos_q;
					if (data_byte[7]) begin
						n_type  = data_byte[5:4];
						n_ver   = '0;
						n_dl    = '0;
						n_sl    = '0;
						n_left  = 16'd4;
						n_phase = PH_VERSION;
					end else if (data_byte[6]) begin
						n_short = pos_q;
						n_outc  = KIND_SHORT;
						n_phase = PH_DONE;
					end else begin
						n_outc  = saw_q ? KIND_UNCERTAIN : KIND_UNTOUCHED;
						n_phase = PH_DONE;
					end
				end
				PH_VERSION: begin
					n_ver  = {ver_q[23:0], data_byte};
					n_left = left_q - 16'd1;
					if (n_left == '0) begin
						if (n_ver == '0) begin
							n_phase = PH_DONE;
							n_outc  = KIND_UNCERTAIN;
						end else begin
							n_phase = PH_DLEN;
						end
					end
				end
				PH_DLEN, PH_SLEN: begin
					if (data_byte > MaxId) begin
						n_phase = PH_DONE;
						n_outc  = KIND_UNCERTAIN;
					end else begin
						n_left = {8'd0, data_byte};
						if (phase_q == PH_DLEN) begin
							n_dl    = data_byte[4:0];
							n_phase = (data_byte == '0) ? PH_SLEN : PH_DBODY;
						end else begin
							n_sl = data_byte[4:0];
							if (data_byte != '0) n_phase = PH_SBODY;
							else if (type_q == TYPE_INITIAL) n_phase = PH_TOKV;
							else if (type_q == TYPE_RETRY) n_phase = PH_RETRY;
							else n_phase = PH_LENV;
						end
					end
				end
				PH_DBODY: begin
					n_left = left_q - 16'd1;
					if (n_left == '0) n_phase = PH_SLEN;
				end
				PH_SBODY: begin
					n_left = left_q - 16'd1;
					if (n_left == '0) begin
						if (type_q == TYPE_INITIAL) n_phase = PH_TOKV;
						else if (type_q == TYPE_RETRY) n_phase = PH_RETRY;
						else n_phase = PH_LENV;
					end
				end
				PH_TOKV, PH_LENV, PH_TOKV_MORE, PH_LENV_MORE: begin
					if (phase_q == PH_TOKV || phase_q == PH_LENV) begin
						n_acc  = {10'd0, data_byte[5:0]};
						n_big  = 1'b0;
						n_left = 16'((17'd1 << data_byte[7:6]) - 17'd1);
					end else begin
						n_acc  = {acc_q[7:0], data_byte};
						n_big  = big_q | (acc_q[15:8] != '0);
						n_left = left_q - 16'd1;
					end
					vzero = (n_acc == '0) && !n_big;
					vover = n_big || (n_acc > MaxPay);
					if (n_left == '0) begin
						if (vzero) begin
							if (phase_q == PH_TOKV || phase_q == PH_TOKV_MORE) begin
								n_phase = PH_LENV;
							end else begin
								ev.pkt_v = 1'b1;
								n_saw    = 1'b1;
								n_phase  = PH_FIRST;
							end
						end else if (vover) begin
							n_phase = PH_DONE;
							n_outc  = KIND_UNCERTAIN;
						end else begin
							n_left  = n_acc;
							n_phase = (phase_q == PH_TOKV || phase_q == PH_TOKV_MORE) ?
								PH_TOKBODY : PH_BODY;
						end
					end else if (phase_q == PH_TOKV) begin
						n_phase = PH_TOKV_MORE;
					end else if (phase_q == PH_LENV) begin
						n_phase = PH_LENV_MORE;
					end
				end
				PH_TOKBODY: begin
					n_left = left_q - 16'd1;
					if (n_left == '0) n_phase = PH_LENV;
				end
				PH_BODY: begin
					n_left = left_q - 16'd1;
					if (n_left == '0) begin
						ev.pkt_v = 1'b1;
						n_saw    = 1'b1;
						n_phase  = PH_FIRST;
					end
				end
				PH_RETRY: begin
				end
				default: begin
					n_phase = PH_DONE;
				end
			endcase
		end

		if (last_byte) begin
			ev.term_v = 1'b1;
			case (n_phase)
				PH_FIRST: ev.term_kind = KIND_ALL_LONG;
				PH_RETRY: begin
					ev.pkt_v     = 1'b1;
					ev.term_kind = KIND_ALL_LONG;
				end
				PH_DONE: begin
					ev.term_kind   = n_outc;
					ev.term_offset = (n_outc == KIND_SHORT) ? n_short : '0;
				end
				default: ev.term_kind = KIND_UNCERTAIN;
			endcase
			n_phase = PH_FIRST;
			n_pos   = '0;
			n_begin = '0;
			n_left  = '0;
			n_acc   = '0;
			n_big   = 1'b0;
			n_ver   = '0;
			n_type  = '0;
			n_dl    = '0;
			n_sl    = '0;
			n_saw   = 1'b0;
			n_outc  = KIND_ALL_LONG;
			n_short = '0;
		end else if (pos_q != 16'hFFFF) begin
			n_pos = pos_q + 16'd1;
		end

		ev.pkt_type   = type_q;
		ev.version    = ver_q;
		ev.dest_len   = dl_q;
		ev.source_len = sl_q;
		ev.pkt_offset = begin_q;
		ev.pkt_size   = size;
		ev_wr         = take && (ev.pkt_v || ev.term_v);
	end

endmodule

`default_nettype wire

>>> design/qlhw_evq.sv
// Short event queue between the walker and the result serializer.
// Stores event records in a small register array. Depends on qlhw_pkg.
`default_nettype none

module qlhw_evq import qlhw_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire event_t wr_data,
	input  wire logic   rd_en,
	output event_t      rd_data,
	output logic        full,
	output logic        empty
);

	localparam int unsigned PtrW = $clog2(EVQ_DEPTH);

	event_t          mem_q [EVQ_DEPTH];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [PtrW:0]   count_q;

	assign full    = (count_q == (PtrW+1)'(EVQ_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en && !full) wptr_q <= wptr_q + PtrW'(1);
			if (rd_en && !empty) rptr_q <= rptr_q + PtrW'(1);
			count_q <= count_q + (PtrW+1)'(wr_en && !full) - (PtrW+1)'(rd_en && !empty);
		end
	end

endmodule

`default_nettype wire

>>> design/qlhw_back.sv
// Back part of the QUIC long-header walker: turns each queued event into one
// or two result items, packet result first. Depends on qlhw_pkg.
`default_nettype none

module qlhw_back import qlhw_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire event_t head,
	input  wire logic   head_empty,
	output logic        head_pop,
	input  wire logic   pop,
	output logic        empty,
	output logic [2:0]  result_kind,
	output logic [1:0]  header_type,
	output logic [31:0] version_word,
	output logic [4:0]  dest_id_length,
	output logic [4:0]  source_id_length,
	output logic [15:0] packet_offset,
	output logic [15:0] packet_size,
	output logic        end_of_payload
);

	logic half_q;
	logic show_pkt;
	logic take;

	assign empty    = head_empty;
	assign show_pkt = head.pkt_v && !half_q;
	assign take     = pop && !head_empty;
	assign head_pop = take && !(show_pkt && head.term_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
		end else if (take) begin
			half_q <= show_pkt && head.term_v;
		end
	end

	always_comb begin
		if (show_pkt) begin
			result_kind      = KIND_PACKET;
			header_type      = head.pkt_type;
			version_word     = head.version;
			dest_id_length   = head.dest_len;
			source_id_length = head.source_len;
			packet_offset    = head.pkt_offset;
			packet_size      = head.pkt_size;
			end_of_payload   = 1'b0;
		end else begin
			result_kind      = head.term_kind;
			header_type      = '0;
			version_word     = '0;
			dest_id_length   = '0;
			source_id_length = '0;
			packet_offset    = head.term_offset;
			packet_size      = '0;
			end_of_payload   = 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> design/quic_long_header_walker.sv
// Top level of the QUIC long-header walker: walker front, event queue and
// result serializer. Depends on qlhw_pkg, qlhw_front, qlhw_evq and qlhw_back.
//
//   Channel   Direction  Handshake          Payload
//   bytes     in         push / full        data_byte, last_byte
//   results   out        empty / pop        result_kind .. end_of_payload
//
// One byte is taken per cycle while the event queue has room.
// A byte that closes a packet or the payload adds one queue entry, which
// leaves as one or two result items, one per cycle while pop is high.
// The queue holds four entries; full rises only when results are not taken.
// Reset clears the walker to the start of a payload and empties the queue.
`default_nettype none

module quic_long_header_walker import qlhw_pkg::*; #(
	parameter int unsigned MAX_ID_BYTES      = MAX_ID_BYTES_DEF,
	parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       result_kind,
	output logic [1:0]       header_type,
	output logic [31:0]      version_word,
	output logic [4:0]       dest_id_length,
	output logic [4:0]       source_id_length,
	output logic [15:0]      packet_offset,
	output logic [15:0]      packet_size,
	output logic             end_of_payload
);

	event_t ev;
	event_t head;
	logic   ev_wr;
	logic   q_full;
	logic   q_empty;
	logic   head_pop;

	assign full = q_full;

	qlhw_front #(
		.MAX_ID_BYTES      (MAX_ID_BYTES),
		.MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (push && !q_full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.ev        (ev),
		.ev_wr     (ev_wr)
	);

	qlhw_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_wr),
		.wr_data (ev),
		.rd_en   (head_pop),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	qlhw_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.head_empty       (q_empty),
		.head_pop         (head_pop),
		.pop              (pop),
		.empty            (empty),
		.result_kind      (result_kind),
		.header_type      (header_type),
		.version_word     (version_word),
		.dest_id_length   (dest_id_length),
		.source_id_length (source_id_length),
		.packet_offset    (packet_offset),
		.packet_size      (packet_size),
		.end_of_payload   (end_of_payload)
	);

	a_no_lost_event: assert property (@(posedge clk) disable iff (!arst_n)
		ev_wr |-> !q_full)
		else $error("event written while the queue is full");

	a_last_makes_event: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && last_byte) |=> !empty)
		else $error("last byte left no result behind");

	a_terminal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_payload) |-> (packet_size == '0 && version_word == '0))
		else $error("terminal result carries packet fields");

	a_packet_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !end_of_payload) |-> (result_kind == KIND_PACKET))
		else $error("packet result with a terminal kind");

endmodule

`default_nettype wire
